FILE: design/capability_checked_mailbox_ipc_macros.svh
// Assertion macros for the mailbox design file capability_checked_mailbox_ipc.sv.
`ifndef CAPABILITY_CHECKED_MAILBOX_IPC_MACROS_SVH
`define CAPABILITY_CHECKED_MAILBOX_IPC_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CCMI_ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("mailbox check failed");

// Condition that must hold at the clock edge after the antecedent.
`define CCMI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mailbox sequence check failed");

`endif

FILE: design/ccmi_pkg.sv
package ccmi_pkg;

   localparam int DEF_AGENTS    = 8;
   localparam int DEF_BOX_DEPTH = 16;

   localparam logic       REQ_SEND = 1'b0;
   localparam logic       REQ_RECV = 1'b1;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_DENIED   = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NO_AGENT = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   localparam int         CSR_IDX_W   = 2;
   localparam logic [1:0] CSR_PRESENT = 2'd0;
   localparam logic [1:0] CSR_ADMIN   = 2'd1;
   localparam logic [1:0] CSR_PERMIT  = 2'd2;

   localparam logic [3:0]  KERNEL_CODE = 4'hF;
   localparam logic [31:0] KERNEL_ID   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        req_type;
      logic        agent_valid;
      logic [2:0]  agent_id;
      logic [7:0]  dest_agent;
      logic [31:0] signal_code;
      logic [63:0] payload_word;
   } ccmi_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] rx_sender;
      logic [31:0] rx_signal;
      logic [63:0] rx_payload;
      logic        wake_request;
      logic [2:0]  wake_agent;
   } ccmi_rsp_type;

   typedef struct packed {
      logic [3:0]  sender;
      logic [31:0] signal_code;
      logic [63:0] payload_word;
   } ccmi_msg_type;

endpackage

FILE: design/ccmi_msg_ram.sv
module ccmi_msg_ram #(
   parameter int DEPTH = ccmi_pkg::DEF_AGENTS * ccmi_pkg::DEF_BOX_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic                  rd_en,
   input  logic [AW-1:0]         addr,
   input  ccmi_pkg::ccmi_msg_type wr_data,
   output ccmi_pkg::ccmi_msg_type rd_data_ff
);

   ccmi_pkg::ccmi_msg_type mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

endmodule

FILE: design/capability_checked_mailbox_ipc.sv
// Per-agent message mailboxes with a send-permission check.
// Requests enter on req_valid/req_stall with a ccmi_req_type payload; a send
// appends a message to the destination's ring, a receive pops the oldest
// message of the current agent. Every request yields exactly one response on
// rsp_valid/rsp_stall, carrying the status, the received message and the wake
// request for the destination of a successful send.
// The csr_ channel writes present_mask, admin_mask and send_permission; it is
// always ready; the user must write it only while no request is in flight, as
// the block does not enforce this. An accepted request is held in the second
// stage and then moves into the response register that drives rsp_valid. The
// pointers and counts are updated at the accepting edge and the single-port
// message memory is accessed there once, so a request can be taken every
// cycle while the response side keeps up.
// When the receiver stalls, the response is held and one further request is
// taken into the second stage; req_stall then rises until the response moves.
// Synchronous reset clears the pointers, counts, masks and valid flags. The
// message memory is not cleared, as the counts only allow written entries to
// be read, so the block takes requests from the first cycle after reset.
`include "capability_checked_mailbox_ipc_macros.svh"

module capability_checked_mailbox_ipc #(
   parameter int AGENTS    = ccmi_pkg::DEF_AGENTS,
   parameter int BOX_DEPTH = ccmi_pkg::DEF_BOX_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ccmi_pkg::ccmi_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ccmi_pkg::ccmi_rsp_type           rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ccmi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                      csr_wdata
);

   localparam int AIW   = (AGENTS > 1) ? $clog2(AGENTS) : 1;
   localparam int PW    = $clog2(BOX_DEPTH);
   localparam int CW    = $clog2(BOX_DEPTH + 1);
   localparam int DEPTH = AGENTS * BOX_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0]   present_ff;
   logic [7:0]   admin_ff;
   logic [63:0]  permit_ff;

   logic [PW-1:0] head_ff  [AGENTS];
   logic [PW-1:0] head_in  [AGENTS];
   logic [PW-1:0] tail_ff  [AGENTS];
   logic [PW-1:0] tail_in  [AGENTS];
   logic [CW-1:0] count_ff [AGENTS];
   logic [CW-1:0] count_in [AGENTS];

   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   logic                   s2_read_ff;
   ccmi_pkg::ccmi_rsp_type s2_rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   ccmi_pkg::ccmi_rsp_type rsp_ff;
   ccmi_pkg::ccmi_rsp_type rsp_in;

   logic                   req_accept;
   logic                   s2_move;
   logic [AIW-1:0]         dst_idx;
   logic [AIW-1:0]         me_idx;
   logic [AIW-1:0]         sel_idx;
   logic [CW-1:0]          sel_count;
   logic                   dst_ok;
   logic                   me_ok;
   logic                   permit_ok;
   logic                   do_write;
   logic                   do_read;
   logic [2:0]             status;
   logic [PW-1:0]          sel_ptr;
   logic [PW-1:0]          ptr_next;
   logic [AW-1:0]          mem_addr;
   logic                   mem_wr_en;
   logic                   mem_rd_en;
   ccmi_pkg::ccmi_msg_type mem_wr_data;
   ccmi_pkg::ccmi_msg_type mem_rd_data;

   assign s2_move    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = reset || (s2_valid_ff && !s2_move);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign dst_idx   = req_data.dest_agent[AIW-1:0];
   assign me_idx    = req_data.agent_id[AIW-1:0];
   assign sel_idx   = (req_data.req_type == ccmi_pkg::REQ_SEND) ? dst_idx : me_idx;
   assign sel_count = count_ff[sel_idx];

   assign dst_ok    = (req_data.dest_agent < 8'(AGENTS))
                      && present_ff[req_data.dest_agent[2:0]];
   assign me_ok     = req_data.agent_valid && ({1'b0, req_data.agent_id} < 4'(AGENTS));
   assign permit_ok = !req_data.agent_valid || admin_ff[req_data.agent_id]
                      || permit_ff[{req_data.agent_id, req_data.dest_agent[2:0]}];

   always_comb begin
      do_write = 1'b0;
      do_read  = 1'b0;
      if (req_data.req_type == ccmi_pkg::REQ_SEND) begin
         priority if (!dst_ok) begin
            status = ccmi_pkg::ST_INVALID;
         end else if (!permit_ok) begin
            status = ccmi_pkg::ST_DENIED;
         end else if (sel_count >= CW'(BOX_DEPTH)) begin
            status = ccmi_pkg::ST_FULL;
         end else begin
            status   = ccmi_pkg::ST_OK;
            do_write = 1'b1;
         end
      end else begin
         priority if (!me_ok) begin
            status = ccmi_pkg::ST_NO_AGENT;
         end else if (sel_count == '0) begin
            status = ccmi_pkg::ST_EMPTY;
         end else begin
            status  = ccmi_pkg::ST_OK;
            do_read = 1'b1;
         end
      end
   end

   assign sel_ptr  = do_write ? tail_ff[sel_idx] : head_ff[sel_idx];
   assign ptr_next = (sel_ptr == PW'(BOX_DEPTH - 1)) ? '0 : sel_ptr + PW'(1);
   assign mem_addr = AW'(sel_idx) * AW'(BOX_DEPTH) + AW'(sel_ptr);

   assign mem_wr_en = req_accept && do_write;
   assign mem_rd_en = req_accept && do_read;

   assign mem_wr_data.sender       = req_data.agent_valid ? {1'b0, req_data.agent_id}
                                                          : ccmi_pkg::KERNEL_CODE;
   assign mem_wr_data.signal_code  = req_data.signal_code;
   assign mem_wr_data.payload_word = req_data.payload_word;

   ccmi_msg_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_msg_ram (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .rd_en      (mem_rd_en),
      .addr       (mem_addr),
      .wr_data    (mem_wr_data),
      .rd_data_ff (mem_rd_data)
   );

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (mem_wr_en) begin
         tail_in[sel_idx]  = ptr_next;
         count_in[sel_idx] = sel_count + CW'(1);
      end
      if (mem_rd_en) begin
         head_in[sel_idx]  = ptr_next;
         count_in[sel_idx] = sel_count - CW'(1);
      end
   end

   always_comb begin
      s2_valid_in  = req_accept || (s2_valid_ff && !s2_move);
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || (s2_valid_ff && s2_move);
      rsp_in       = s2_rsp_ff;
      if (s2_read_ff) begin
         rsp_in.rx_sender  = (mem_rd_data.sender == ccmi_pkg::KERNEL_CODE)
                             ? ccmi_pkg::KERNEL_ID : 32'(mem_rd_data.sender);
         rsp_in.rx_signal  = mem_rd_data.signal_code;
         rsp_in.rx_payload = mem_rd_data.payload_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         admin_ff     <= '0;
         permit_ff    <= '0;
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ccmi_pkg::CSR_PRESENT: present_ff <= csr_wdata[7:0];
               ccmi_pkg::CSR_ADMIN:   admin_ff   <= csr_wdata[7:0];
               ccmi_pkg::CSR_PERMIT:  permit_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s2_read_ff             <= do_read;
         s2_rsp_ff.status       <= status;
         s2_rsp_ff.rx_sender    <= '0;
         s2_rsp_ff.rx_signal    <= '0;
         s2_rsp_ff.rx_payload   <= '0;
         s2_rsp_ff.wake_request <= do_write;
         s2_rsp_ff.wake_agent   <= do_write ? req_data.dest_agent[2:0] : 3'd0;
      end
      if (s2_valid_ff && s2_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CCMI_ASSERT_NOW(a_one_mem_access, clock, reset, !(mem_wr_en && mem_rd_en))
   `CCMI_ASSERT_NOW(a_count_bound, clock, reset, sel_count <= CW'(BOX_DEPTH))
   `CCMI_ASSERT_NEXT(a_accept_fills_s2, clock, reset, req_accept, s2_valid_ff)
   `CCMI_ASSERT_NOW(a_wake_only_ok, clock, reset,
                    !(rsp_valid_ff && rsp_ff.wake_request) || (rsp_ff.status == ccmi_pkg::ST_OK))
   `CCMI_ASSERT_NEXT(a_s2_holds, clock, reset, s2_valid_ff && !s2_move,
                     s2_valid_ff && $stable(s2_read_ff) && $stable(s2_rsp_ff))

endmodule
